@@ hw/rtl/bmpd_pkg.sv @@
// Shared types and constants for the BMP pixel stream decoder.
// No dependencies; every other RTL file of the decoder imports this package.
`default_nettype none

package bmpd_pkg;

    // Image size limits
    localparam int unsigned MAX_WIDTH  = 4096;
    localparam int unsigned MAX_HEIGHT = 4096;

    // Field widths
    localparam int unsigned COORD_W = 12;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned POS_W   = 10;

    // Header layout (byte offsets in the file; the palette end counts from the start of the palette)
    localparam logic [POS_W-1:0] POS_SIG0    = 10'd0;
    localparam logic [POS_W-1:0] POS_SIG1    = 10'd1;
    localparam logic [POS_W-1:0] POS_W0      = 10'd18;
    localparam logic [POS_W-1:0] POS_W3      = 10'd21;
    localparam logic [POS_W-1:0] POS_H0      = 10'd22;
    localparam logic [POS_W-1:0] POS_H3      = 10'd25;
    localparam logic [POS_W-1:0] POS_BPP0    = 10'd28;
    localparam logic [POS_W-1:0] POS_BPP1    = 10'd29;
    localparam logic [POS_W-1:0] POS_HDR_END = 10'd53;
    localparam logic [POS_W-1:0] POS_PAL_END = 10'd1023;

    // Signature and supported depths
    localparam logic [7:0]  SIG_B    = 8'h42;
    localparam logic [7:0]  SIG_M    = 8'h4D;
    localparam logic [15:0] BPP_PAL  = 16'd8;
    localparam logic [15:0] BPP_TRUE = 16'd24;

    // Command queue sizing
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        ST_PIXEL     = 2'd0,
        ST_BAD_SIG   = 2'd1,
        ST_BAD_DEPTH = 2'd2,
        ST_TOO_LARGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CMD_PAL_WR  = 2'd0,
        CMD_PIX_IDX = 2'd1,
        CMD_PIX_RGB = 2'd2,
        CMD_ERROR   = 2'd3
    } t_cmd_kind;

    // One unit of work for the back end
    typedef struct packed {
        t_cmd_kind          kind;
        t_status            status;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
        logic [7:0]         index;
        logic [23:0]        color;   // red, green, blue from high to low
    } t_cmd;

endpackage

`default_nettype wire

@@ hw/rtl/bmpd_if.sv @@
// Valid/ready channel interfaces for the BMP decoder: byte input and pixel output.
// Depends on bmpd_pkg for field widths.
`default_nettype none

interface bmpd_in_if;
    import bmpd_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       file_end;

    modport source (output valid, output data_byte, output file_end, input ready);
    modport sink   (input valid, input data_byte, input file_end, output ready);
endinterface

interface bmpd_out_if;
    import bmpd_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic               last_pixel;

    modport source (output valid, output status, output pixel_x, output pixel_y,
                    output red, output green, output blue, output last_pixel,
                    input ready);
    modport sink   (input valid, input status, input pixel_x, input pixel_y,
                    input red, input green, input blue, input last_pixel,
                    output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bmp_pixel_stream_decoder_core.sv @@
// Top level of the BMP pixel stream decoder: front end, command queue, back end.
// Depends on bmpd_pkg, bmpd_if, bmpd_front, bmpd_queue and bmpd_back.
//
//   Channel  Dir  Handshake      Payload
//   i_in     in   valid/ready    data_byte[7:0], file_end
//   o_out    out  valid/ready    status[1:0], pixel_x[11:0], pixel_y[11:0],
//                                red[7:0], green[7:0], blue[7:0], last_pixel
//
// One byte is accepted per cycle while the command queue is not full; a pixel passes
// through a queue slot, the palette read stage and the output register in turn.
// Reset is synchronous, active low; it clears parser and pipeline control but
// not the 256-entry palette memory, so no clearing pass follows reset.
// An output stall fills the output register, the lookup stage and the
// four-entry command queue before i_in.ready drops.
`default_nettype none

module bmp_pixel_stream_decoder_core (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    bmpd_in_if.sink      i_in,
    bmpd_out_if.source   o_out
);
    import bmpd_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic front_push;
    logic queue_full;
    logic queue_not_empty;
    logic back_pop;

    bmpd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_data_byte (i_in.data_byte),
        .i_file_end  (i_in.file_end),
        .i_full      (queue_full),
        .o_push      (front_push),
        .o_cmd       (front_cmd)
    );

    bmpd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (front_push),
        .i_cmd       (front_cmd),
        .o_full      (queue_full),
        .i_pop       (back_pop),
        .o_not_empty (queue_not_empty),
        .o_cmd       (queue_cmd)
    );

    bmpd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (queue_not_empty),
        .i_cmd        (queue_cmd),
        .o_pop        (back_pop),
        .o_valid      (o_out.valid),
        .i_ready      (o_out.ready),
        .o_status     (o_out.status),
        .o_pixel_x    (o_out.pixel_x),
        .o_pixel_y    (o_out.pixel_y),
        .o_red        (o_out.red),
        .o_green      (o_out.green),
        .o_blue       (o_out.blue),
        .o_last_pixel (o_out.last_pixel)
    );

endmodule

`default_nettype wire

@@ hw/rtl/bmpd_front.sv @@
// Front end of the BMP decoder: parses header, palette and pixel bytes and
// issues commands to the queue. Depends on bmpd_pkg.
`default_nettype none

module bmpd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_file_end,
    input  wire logic          i_full,
    output logic               o_push,
    output bmpd_pkg::t_cmd     o_cmd
);
    import bmpd_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_PALETTE,
        PH_PIXELS,
        PH_PAD,
        PH_IGNORE
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic               r_sig_ok, n_sig_ok;
    logic [31:0]        r_width, n_width;
    logic [31:0]        r_height, n_height;
    logic [15:0]        r_bpp, n_bpp;
    logic [COORD_W-1:0] r_col, n_col;
    logic [COORD_W-1:0] r_row, n_row;
    logic [1:0]         r_bip, n_bip;
    logic [1:0]         r_pad, n_pad;
    logic [15:0]        r_bg, n_bg;

    logic               accept;
    logic               cmd_valid;
    logic               do_pixel;
    logic               do_finish;
    logic [1:0]         lane;
    logic [15:0]        bpp_full;
    logic [COORD_W:0]   col_inc;
    logic [COORD_W:0]   row_inc;
    logic [1:0]         pad_amt;
    logic [1:0]         pad_dec;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && cmd_valid;

    // Byte lane within a 32-bit header field (offsets 18 and 22 map to lane 0)
    assign lane     = r_pos[1:0] - 2'd2;
    assign bpp_full = {i_data_byte, r_bpp[7:0]};
    assign col_inc  = {1'b0, r_col} + 13'd1;
    assign row_inc  = {1'b0, r_row} + 13'd1;
    assign pad_amt  = (r_bpp == BPP_TRUE) ? r_width[1:0] : 2'd0 - r_width[1:0];
    assign pad_dec  = r_pad - 2'd1;

    // Parse one byte
    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_sig_ok  = r_sig_ok;
        n_width   = r_width;
        n_height  = r_height;
        n_bpp     = r_bpp;
        n_col     = r_col;
        n_row     = r_row;
        n_bip     = r_bip;
        n_pad     = r_pad;
        n_bg      = r_bg;
        cmd_valid = 1'b0;
        do_pixel  = 1'b0;
        do_finish = 1'b0;
        o_cmd     = '0;

        if (accept) begin
            case (r_phase)
                PH_HEADER: begin
                    n_pos = r_pos + 10'd1;
                    if (r_pos == POS_SIG0) begin
                        n_sig_ok = (i_data_byte == SIG_B);
                    end else if (r_pos == POS_SIG1) begin
                        if (!(r_sig_ok && i_data_byte == SIG_M)) begin
                            cmd_valid    = 1'b1;
                            o_cmd.kind   = CMD_ERROR;
                            o_cmd.status = ST_BAD_SIG;
                            n_phase      = PH_IGNORE;
                        end
                    end else if (r_pos inside {[POS_W0:POS_W3]}) begin
                        n_width[8*lane +: 8] = i_data_byte;
                    end else if (r_pos inside {[POS_H0:POS_H3]}) begin
                        n_height[8*lane +: 8] = i_data_byte;
                    end else if (r_pos == POS_BPP0) begin
                        n_bpp = {8'd0, i_data_byte};
                    end else if (r_pos == POS_BPP1) begin
                        n_bpp = bpp_full;
                        if (bpp_full != BPP_PAL && bpp_full != BPP_TRUE) begin
                            cmd_valid    = 1'b1;
                            o_cmd.kind   = CMD_ERROR;
                            o_cmd.status = ST_BAD_DEPTH;
                            n_phase      = PH_IGNORE;
                        end else if (r_width > 32'(MAX_WIDTH)
                                     || r_height > 32'(MAX_HEIGHT)) begin
                            cmd_valid    = 1'b1;
                            o_cmd.kind   = CMD_ERROR;
                            o_cmd.status = ST_TOO_LARGE;
                            n_phase      = PH_IGNORE;
                        end else if (r_width == 32'd0 || r_height == 32'd0) begin
                            n_phase = PH_IGNORE;
                        end
                    end else if (r_pos == POS_HDR_END) begin
                        n_pos   = '0;
                        n_phase = (r_bpp == BPP_PAL) ? PH_PALETTE : PH_PIXELS;
                    end
                end
                PH_PALETTE: begin
                    n_pos = r_pos + 10'd1;
                    case (r_pos[1:0])
                        2'd0: n_bg = {8'd0, i_data_byte};
                        2'd1: n_bg = {i_data_byte, r_bg[7:0]};
                        2'd2: begin
                            cmd_valid   = 1'b1;
                            o_cmd.kind  = CMD_PAL_WR;
                            o_cmd.index = r_pos[9:2];
                            o_cmd.color = {i_data_byte, r_bg};
                        end
                        default: ;
                    endcase
                    if (r_pos == POS_PAL_END) begin
                        n_pos   = '0;
                        n_phase = PH_PIXELS;
                    end
                end
                PH_PIXELS: begin
                    if (r_bpp == BPP_PAL) begin
                        do_pixel    = 1'b1;
                        o_cmd.kind  = CMD_PIX_IDX;
                        o_cmd.index = i_data_byte;
                    end else begin
                        case (r_bip)
                            2'd0: begin
                                n_bg  = {8'd0, i_data_byte};
                                n_bip = 2'd1;
                            end
                            2'd1: begin
                                n_bg  = {i_data_byte, r_bg[7:0]};
                                n_bip = 2'd2;
                            end
                            default: begin
                                n_bip       = 2'd0;
                                do_pixel    = 1'b1;
                                o_cmd.kind  = CMD_PIX_RGB;
                                o_cmd.color = {i_data_byte, r_bg[15:8], r_bg[7:0]};
                            end
                        endcase
                    end
                end
                PH_PAD: begin
                    if (r_pad != 2'd0) begin
                        n_pad = pad_dec;
                    end
                    if (r_pad == 2'd0 || pad_dec == 2'd0) begin
                        do_finish = 1'b1;
                    end
                end
                default: ;
            endcase

            // Emit a pixel and advance column, row and padding
            if (do_pixel) begin
                cmd_valid    = 1'b1;
                o_cmd.status = ST_PIXEL;
                o_cmd.x      = r_col;
                o_cmd.y      = r_height[COORD_W-1:0] - 12'd1 - r_row;
                o_cmd.last   = (col_inc == r_width[COORD_W:0])
                               && (row_inc == r_height[COORD_W:0]);
                if (col_inc >= r_width[COORD_W:0]) begin
                    n_col = '0;
                    if (pad_amt != 2'd0) begin
                        n_pad   = pad_amt;
                        n_phase = PH_PAD;
                    end else begin
                        do_finish = 1'b1;
                    end
                end else begin
                    n_col = col_inc[COORD_W-1:0];
                end
            end

            // Close a file row
            if (do_finish) begin
                n_row   = row_inc[COORD_W-1:0];
                n_phase = (row_inc >= r_height[COORD_W:0]) ? PH_IGNORE : PH_PIXELS;
            end

            // Drop all parse state after the last byte of the file
            if (i_file_end) begin
                n_phase  = PH_HEADER;
                n_pos    = '0;
                n_sig_ok = 1'b0;
                n_width  = '0;
                n_height = '0;
                n_bpp    = '0;
                n_col    = '0;
                n_row    = '0;
                n_bip    = '0;
                n_pad    = '0;
                n_bg     = '0;
            end
        end
    end

    // Hold parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_pos    <= '0;
            r_sig_ok <= 1'b0;
            r_width  <= '0;
            r_height <= '0;
            r_bpp    <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_bip    <= '0;
            r_pad    <= '0;
            r_bg     <= '0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_sig_ok <= n_sig_ok;
            r_width  <= n_width;
            r_height <= n_height;
            r_bpp    <= n_bpp;
            r_col    <= n_col;
            r_row    <= n_row;
            r_bip    <= n_bip;
            r_pad    <= n_pad;
            r_bg     <= n_bg;
        end
    end

`ifndef ASSERT_OFF
    // Pixel rows are only walked for a supported depth
    a_pixels_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PIXELS) |-> (r_bpp == BPP_PAL || r_bpp == BPP_TRUE))
        else $error("pixel phase with unsupported depth");

    // The column stays inside the image while pixels are parsed
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PIXELS) |-> ({1'b0, r_col} < r_width[COORD_W:0]))
        else $error("column beyond image width");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/bmpd_queue.sv @@
// Short command queue between the decoder front and back ends.
// Depends on bmpd_pkg for the command type and depth.
`default_nettype none

module bmpd_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire bmpd_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_not_empty,
    output bmpd_pkg::t_cmd     o_cmd
);
    import bmpd_pkg::*;

    t_cmd              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full      = (r_count == QCNT_W'(QDEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_cmd       = r_slot[r_rd_ptr];
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && o_not_empty;

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    // Store commands
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

`ifndef ASSERT_OFF
    // The front end never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full command queue");

    // Occupancy matches the pointer distance
    a_count_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == QCNT_W'(QDEPTH)) || (QPTR_W'(r_count) == QPTR_W'(r_wr_ptr - r_rd_ptr)))
        else $error("queue count and pointers disagree");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/bmpd_back.sv @@
// Back end of the BMP decoder: palette memory, lookup stage and output register.
// Depends on bmpd_pkg for the command type.
`default_nettype none

module bmpd_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cmd_valid,
    input  wire bmpd_pkg::t_cmd               i_cmd,
    output logic                              o_pop,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [1:0]                        o_status,
    output logic [bmpd_pkg::COORD_W-1:0]      o_pixel_x,
    output logic [bmpd_pkg::COORD_W-1:0]      o_pixel_y,
    output logic [bmpd_pkg::CHAN_W-1:0]       o_red,
    output logic [bmpd_pkg::CHAN_W-1:0]       o_green,
    output logic [bmpd_pkg::CHAN_W-1:0]       o_blue,
    output logic                              o_last_pixel
);
    import bmpd_pkg::*;

    logic [23:0]        r_palette [256];
    logic [23:0]        r_rd_color;
    t_cmd               r_s1_cmd;
    logic               r_s1_valid, n_s1_valid;
    logic               r_out_valid, n_out_valid;
    logic [1:0]         r_out_status;
    logic [COORD_W-1:0] r_out_x;
    logic [COORD_W-1:0] r_out_y;
    logic [23:0]        r_out_color;
    logic               r_out_last;

    logic               out_load;
    logic               s1_free;
    logic               pop_wr;
    logic               pop_s1;
    logic [23:0]        s1_color;

    assign out_load = r_s1_valid && (!r_out_valid || i_ready);
    assign s1_free  = !r_s1_valid || out_load;
    assign o_pop    = i_cmd_valid && s1_free;
    assign pop_wr   = o_pop && (i_cmd.kind == CMD_PAL_WR);
    assign pop_s1   = o_pop && (i_cmd.kind != CMD_PAL_WR);
    assign s1_color = (r_s1_cmd.kind == CMD_PIX_IDX) ? r_rd_color : r_s1_cmd.color;

    always_comb begin
        n_s1_valid  = s1_free ? pop_s1 : r_s1_valid;
        n_out_valid = out_load ? 1'b1 : (i_ready ? 1'b0 : r_out_valid);
    end

    // Write palette entries, look up indexed pixels
    always_ff @(posedge i_clk) begin
        if (pop_wr) begin
            r_palette[i_cmd.index] <= i_cmd.color;
        end
        if (pop_s1) begin
            r_rd_color <= r_palette[i_cmd.index];
        end
    end

    // Lookup stage and output register payload
    always_ff @(posedge i_clk) begin
        if (s1_free) begin
            r_s1_cmd <= i_cmd;
        end
        if (out_load) begin
            r_out_status <= r_s1_cmd.status;
            r_out_x      <= r_s1_cmd.x;
            r_out_y      <= r_s1_cmd.y;
            r_out_color  <= s1_color;
            r_out_last   <= r_s1_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_pixel_x    = r_out_x;
    assign o_pixel_y    = r_out_y;
    assign o_red        = r_out_color[23:16];
    assign o_green      = r_out_color[15:8];
    assign o_blue       = r_out_color[7:0];
    assign o_last_pixel = r_out_last;

`ifndef ASSERT_OFF
    // A stalled output keeps the lookup stage occupied
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_ready) |=> r_s1_valid)
        else $error("lookup stage lost an item under stall");
`endif

endmodule

`default_nettype wire

@@ dv/bmp_pixel_stream_decoder_core_tb.sv @@
// Testbench for bmp_pixel_stream_decoder_core: streams whole, truncated and broken
// bitmap files into the byte channel and checks every pixel or error transaction.
// Depends on bmpd_pkg, bmpd_if and the decoder RTL; needs no files or arguments.
module bmp_pixel_stream_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bmpd_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_BYTES = 80;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int HDR_BYTES    = 54;

    typedef enum logic [2:0] {
        PARSE_HEADER,
        PARSE_PALETTE,
        PARSE_PIXELS,
        PARSE_PAD,
        PARSE_IGNORE
    } parse_phase_e;

    typedef struct packed {
        t_status             status;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [CHAN_W-1:0]   red;
        logic [CHAN_W-1:0]   green;
        logic [CHAN_W-1:0]   blue;
        logic                last;
    } pixel_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bmpd_in_if  in_ch ();
    bmpd_out_if out_ch ();

    bmp_pixel_stream_decoder_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Decoder state as the bench sees it
    logic [10:0]   hdr_pos;
    logic          sig_ok;
    logic [31:0]   img_w;
    logic [31:0]   img_h;
    logic [15:0]   img_bpp;
    logic [23:0]   palette [256];
    int unsigned   col;
    int unsigned   file_row;
    logic [1:0]    pix_byte;
    logic [1:0]    pad_left;
    logic [15:0]   partial_bg;
    parse_phase_e  phase;

    pixel_result_t pending_pixels [$];
    logic [7:0]    bmp_bytes [$];
    int            error_count = 0;
    int            cycle_count = 0;
    int            burst_left  = 0;
    int            stall_left  = 0;
    int            mode_left   = 0;
    int            sink_mode   = 0;

    // Return the parser to its idle state; the palette survives
    function automatic void clear_parser();
        hdr_pos    = '0;
        sig_ok     = 1'b0;
        img_w      = '0;
        img_h      = '0;
        img_bpp    = '0;
        col        = 0;
        file_row   = 0;
        pix_byte   = '0;
        pad_left   = '0;
        partial_bg = '0;
        phase      = PARSE_HEADER;
    endfunction

    function automatic void push_error(t_status code);
        pixel_result_t res;
        res = '0;
        res.status = code;
        pending_pixels.push_back(res);
        phase = PARSE_IGNORE;
    endfunction

    function automatic void end_row();
        file_row++;
        phase = (file_row >= img_h) ? PARSE_IGNORE : PARSE_PIXELS;
    endfunction

    // Queue one pixel, then advance column, row and padding
    function automatic void emit_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        pixel_result_t res;
        logic [31:0]   row_top;
        logic [1:0]    pad;
        row_top    = img_h - 32'd1 - file_row;
        res.status = ST_PIXEL;
        res.x      = col[COORD_W-1:0];
        res.y      = row_top[COORD_W-1:0];
        res.red    = r;
        res.green  = g;
        res.blue   = b;
        res.last   = (col + 1 == img_w) && (file_row + 1 == img_h);
        pending_pixels.push_back(res);
        col++;
        if (col >= img_w) begin
            col = 0;
            pad = (img_bpp == BPP_TRUE) ? img_w[1:0] : 2'd0 - img_w[1:0];
            if (pad != 2'd0) begin
                pad_left = pad;
                phase    = PARSE_PAD;
            end else begin
                end_row();
            end
        end
    endfunction

    // Work out the result, if any, of one accepted byte
    function automatic void predict_decode(logic [7:0] b, logic fe);
        logic [10:0] p;
        logic [23:0] entry;
        case (phase)
            PARSE_HEADER: begin
                p = hdr_pos;
                hdr_pos = hdr_pos + 11'd1;
                if (p == POS_SIG0) begin
                    sig_ok = (b == SIG_B);
                end else if (p == POS_SIG1) begin
                    if (!(sig_ok && b == SIG_M))
                        push_error(ST_BAD_SIG);
                end else if (p >= POS_W0 && p <= POS_W3) begin
                    img_w |= 32'(b) << (8 * (p - POS_W0));
                end else if (p >= POS_H0 && p <= POS_H3) begin
                    img_h |= 32'(b) << (8 * (p - POS_H0));
                end else if (p == POS_BPP0) begin
                    img_bpp = {8'd0, b};
                end else if (p == POS_BPP1) begin
                    img_bpp = {b, img_bpp[7:0]};
                    // depth is judged before size
                    if (img_bpp != BPP_PAL && img_bpp != BPP_TRUE)
                        push_error(ST_BAD_DEPTH);
                    else if (img_w > MAX_WIDTH || img_h > MAX_HEIGHT)
                        push_error(ST_TOO_LARGE);
                    else if (img_w == 0 || img_h == 0)
                        phase = PARSE_IGNORE;
                end else if (p == POS_HDR_END) begin
                    hdr_pos = '0;
                    phase = (img_bpp == BPP_PAL) ? PARSE_PALETTE : PARSE_PIXELS;
                end
            end
            PARSE_PALETTE: begin
                p = hdr_pos;
                hdr_pos = hdr_pos + 11'd1;
                case (p[1:0])
                    2'd0: partial_bg = {8'd0, b};
                    2'd1: partial_bg[15:8] = b;
                    2'd2: palette[p[9:2]] = {b, partial_bg};
                    default: ;
                endcase
                if (p >= POS_PAL_END) begin
                    hdr_pos = '0;
                    phase = PARSE_PIXELS;
                end
            end
            PARSE_PIXELS: begin
                if (img_bpp == BPP_PAL) begin
                    entry = palette[b];
                    emit_pixel(entry[23:16], entry[15:8], entry[7:0]);
                end else if (pix_byte == 2'd0) begin
                    partial_bg = {8'd0, b};
                    pix_byte = 2'd1;
                end else if (pix_byte == 2'd1) begin
                    partial_bg[15:8] = b;
                    pix_byte = 2'd2;
                end else begin
                    pix_byte = 2'd0;
                    emit_pixel(b, partial_bg[15:8], partial_bg[7:0]);
                end
            end
            PARSE_PAD: begin
                if (pad_left != 2'd0)
                    pad_left--;
                if (pad_left == 2'd0)
                    end_row();
            end
            default: ;
        endcase
        if (fe)
            clear_parser();
    endfunction

    // File builders: header with random filler, rows, raw noise
    function automatic void add_noise(int n);
        for (int i = 0; i < n; i++)
            bmp_bytes.push_back(8'($urandom()));
    endfunction

    function automatic void start_file(logic [31:0] w, logic [31:0] h, logic [15:0] bpp);
        bmp_bytes.delete();
        add_noise(HDR_BYTES);
        bmp_bytes[POS_SIG0] = SIG_B;
        bmp_bytes[POS_SIG1] = SIG_M;
        for (int i = 0; i < 4; i++) begin
            bmp_bytes[POS_W0 + i] = w[8*i +: 8];
            bmp_bytes[POS_H0 + i] = h[8*i +: 8];
        end
        bmp_bytes[POS_BPP0] = bpp[7:0];
        bmp_bytes[POS_BPP1] = bpp[15:8];
    endfunction

    function automatic void add_rows(int w, logic [15:0] bpp, int rows);
        int row_len;
        row_len = (bpp == BPP_TRUE) ? 3 * w + (w % 4) : w + (4 - w % 4) % 4;
        add_noise(row_len * rows);
    endfunction

    function automatic void cut_file(int keep);
        while (bmp_bytes.size() > keep)
            void'(bmp_bytes.pop_back());
    endfunction

    // Send one byte transaction, with a random gap between bursts
    task automatic send_byte(input logic [7:0] data, input logic last_byte);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= data;
        in_ch.file_end  <= last_byte;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        predict_decode(data, last_byte);
        @(negedge i_clk);
    endtask

    task automatic send_file();
        for (int i = 0; i < bmp_bytes.size(); i++)
            send_byte(bmp_bytes[i], i == bmp_bytes.size() - 1);
    endtask

    // Hold the sender until every expected transaction has come out
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic test_signature();
        // wrong first letter, then wrong second letter
        bmp_bytes.delete();
        bmp_bytes.push_back(8'h43);
        bmp_bytes.push_back(SIG_M);
        add_noise(3);
        send_file();
        bmp_bytes.delete();
        bmp_bytes.push_back(SIG_B);
        bmp_bytes.push_back(8'h4E);
        add_noise(3);
        send_file();
        // one-byte file, then swapped letters ending on the second byte
        bmp_bytes.delete();
        bmp_bytes.push_back(SIG_B);
        send_file();
        bmp_bytes.delete();
        bmp_bytes.push_back(SIG_M);
        bmp_bytes.push_back(SIG_B);
        send_file();
        wait_drained();
    endtask

    task automatic test_depth();
        logic [15:0] depths [3];
        depths = '{16'd16, 16'h0118, 16'hFFFF};
        // file ends on the depth byte that raises the error
        foreach (depths[i]) begin
            start_file(3, 2, depths[i]);
            cut_file(POS_BPP1 + 1);
            send_file();
        end
        // bad depth wins over a size that is too large
        start_file(5000, 5000, 16'd16);
        cut_file(POS_BPP1 + 2);
        send_file();
        wait_drained();
    endtask

    task automatic test_size();
        start_file(MAX_WIDTH + 1, 1, BPP_TRUE);
        cut_file(POS_BPP1 + 1);
        send_file();
        start_file(1, MAX_HEIGHT + 1, BPP_PAL);
        cut_file(POS_BPP1 + 2);
        send_file();
        // widest allowed row is accepted
        start_file(MAX_WIDTH, 1, BPP_TRUE);
        add_noise(6);
        send_file();
        // empty images give nothing at all
        start_file(0, 3, BPP_TRUE);
        cut_file(POS_BPP1 + 7);
        send_file();
        wait_drained();
    endtask

    task automatic test_small_images();
        // padding of one and three bytes, trailing bytes on the last
        start_file(1, 2, BPP_TRUE);
        add_rows(1, BPP_TRUE, 2);
        send_file();
        start_file(3, 1, BPP_TRUE);
        add_rows(3, BPP_TRUE, 1);
        add_noise(3);
        send_file();
        // file ends inside a pixel, the palette and the header
        start_file(3, 2, BPP_TRUE);
        add_rows(3, BPP_TRUE, 2);
        cut_file(HDR_BYTES + 4);
        send_file();
        start_file(2, 1, BPP_PAL);
        add_noise(12);
        send_file();
        start_file(2, 2, BPP_TRUE);
        cut_file(20);
        send_file();
        wait_drained();
    endtask

    task automatic test_extremes();
        // tallest image: only the bottom row, then stop
        start_file(1, MAX_HEIGHT, BPP_TRUE);
        add_rows(1, BPP_TRUE, 1);
        send_file();
        // full-scale and zero colors, two bytes of padding
        start_file(2, 1, BPP_TRUE);
        for (int i = 0; i < 3; i++)
            bmp_bytes.push_back(8'hFF);
        for (int i = 0; i < 3; i++)
            bmp_bytes.push_back(8'h00);
        add_noise(2);
        send_file();
        wait_drained();
    endtask

    task automatic test_random();
        int          sent;
        int          kind;
        int          w;
        int          h;
        logic [31:0] wide_w;
        logic [31:0] wide_h;
        logic [15:0] bpp;
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            kind = $urandom_range(0, 19);
            if (kind < 14) begin
                // true-color file with random content, sometimes with trailing bytes or cut short
                w = $urandom_range(1, 4);
                h = $urandom_range(1, 3);
                start_file(w, h, BPP_TRUE);
                add_rows(w, BPP_TRUE, h);
                if ($urandom_range(0, 2) == 0)
                    add_noise($urandom_range(1, 8));
                if ($urandom_range(0, 9) == 0)
                    cut_file($urandom_range(1, bmp_bytes.size()));
            end else if (kind < 17) begin
                // header with random sizes, depth and sometimes signature
                wide_w = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 5000);
                wide_h = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 5000);
                if ($urandom_range(0, 2) == 0)
                    bpp = 16'($urandom());
                else
                    bpp = $urandom_range(0, 1) ? BPP_PAL : BPP_TRUE;
                start_file(wide_w, wide_h, bpp);
                if ($urandom_range(0, 3) == 0)
                    bmp_bytes[$urandom_range(0, 1)] = 8'($urandom());
                add_noise($urandom_range(1, 40));
            end else begin
                bmp_bytes.delete();
                add_noise($urandom_range(1, 60));
            end
            sent += bmp_bytes.size();
            send_file();
            if ($urandom_range(0, 15) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    // Output stalls: stretches of always-ready, light stalls and heavy stalls
    always @(negedge i_clk) begin : drive_sink_ready
        if (mode_left == 0) begin
            mode_left = $urandom_range(50, 400);
            sink_mode = $urandom_range(0, 2);
        end
        mode_left--;
        if (stall_left != 0) begin
            out_ch.ready <= 1'b0;
            stall_left--;
        end else begin
            out_ch.ready <= 1'b1;
            if (sink_mode == 1 && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 3);
            else if (sink_mode == 2 && $urandom_range(0, 1) == 0)
                stall_left = $urandom_range(1, 12);
        end
    end

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            error_count++;
        end
    endfunction

    // Compare each output transaction with the oldest expectation
    always @(posedge i_clk) begin : check_results
        pixel_result_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected transaction: expected none, %s %0d x %0d y %0d",
                         $time, "actual status", out_ch.status, out_ch.pixel_x,
                         out_ch.pixel_y);
                error_count++;
            end else begin
                want = pending_pixels.pop_front();
                check_field("status", want.status, out_ch.status);
                check_field("pixel_x", want.x, out_ch.pixel_x);
                check_field("pixel_y", want.y, out_ch.pixel_y);
                check_field("red", want.red, out_ch.red);
                check_field("green", want.green, out_ch.green);
                check_field("blue", want.blue, out_ch.blue);
                check_field("last_pixel", want.last, out_ch.last_pixel);
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin : run_tests
        in_ch.valid     = 1'b0;
        in_ch.data_byte = 8'd0;
        in_ch.file_end  = 1'b0;
        out_ch.ready    = 1'b0;
        i_rst_n         = 1'b0;
        clear_parser();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_signature();
        test_depth();
        test_size();
        test_small_images();
        test_extremes();
        test_random();

        wait_drained();
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ bmp_pixel_stream_decoder_core.f @@
hw/rtl/bmpd_pkg.sv
hw/rtl/bmpd_if.sv
hw/rtl/bmpd_front.sv
hw/rtl/bmpd_queue.sv
hw/rtl/bmpd_back.sv
hw/rtl/bmp_pixel_stream_decoder_core.sv
dv/bmp_pixel_stream_decoder_core_tb.sv
